>>> sv/k2e_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and tables of the Keplerian to equinoctial converter.
package k2e_pkg;

    localparam int ANGLE_BITS_DEF    = 32;
    localparam int CORDIC_STAGES_DEF = 30;

    localparam int A_W     = 48;
    localparam int E_W     = 32;
    localparam int ANG_W   = 32;
    localparam int XY_W    = 34;
    localparam int Z_W     = 34;
    localparam int TRIG_W  = 32;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 38;
    localparam int QUO_W   = 33;
    localparam int OUT_W   = 32;
    localparam int PP_W    = 56;
    localparam int MAG_W   = 56;
    localparam int EPROD_W = 65;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = XY_W'(652032874);

    localparam logic [31:0] ARC_TABLE [32] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
        32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
        32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1, 32'd0, 32'd0
    };

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic den_zero;
        logic den_neg;
        logic h_zero;
        logic h_neg;
        logic k_zero;
        logic k_neg;
    } tilt_flags_t;

    typedef struct packed {
        logic signed [A_W-1:0]   semilatus;
        logic                    p_sat;
        logic signed [OUT_W-1:0] ecc_cos;
        logic signed [OUT_W-1:0] ecc_sin;
        logic                    ecc_sat;
        logic [ANG_W-1:0]        lsum;
        tilt_flags_t             flags;
    } side_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } tilt_res_t;

endpackage

>>> sv/k2e_in_if.sv
`timescale 1ns / 1ps
// Input channel carrying one set of Keplerian elements.
interface k2e_in_if;
    logic                  valid;
    logic                  ready;
    logic signed [47:0]    semimajor_km;
    logic [31:0]           eccentricity;
    logic [31:0]           inclination;
    logic [31:0]           node_longitude;
    logic [31:0]           perigee_argument;
    logic [31:0]           anomaly;

    modport source (
        output valid, semimajor_km, eccentricity, inclination, node_longitude,
               perigee_argument, anomaly,
        input  ready
    );
    modport sink (
        input  valid, semimajor_km, eccentricity, inclination, node_longitude,
               perigee_argument, anomaly,
        output ready
    );
endinterface

>>> sv/k2e_out_if.sv
`timescale 1ns / 1ps
// Output channel carrying one set of equinoctial elements.
interface k2e_out_if;
    logic                  valid;
    logic                  ready;
    logic signed [47:0]    semilatus_km;
    logic signed [31:0]    ecc_cos;
    logic signed [31:0]    ecc_sin;
    logic signed [31:0]    tilt_cos;
    logic signed [31:0]    tilt_sin;
    logic [31:0]           longitude_sum;
    logic                  saturated;

    modport source (
        output valid, semilatus_km, ecc_cos, ecc_sin, tilt_cos, tilt_sin,
               longitude_sum, saturated,
        input  ready
    );
    modport sink (
        input  valid, semilatus_km, ecc_cos, ecc_sin, tilt_cos, tilt_sin,
               longitude_sum, saturated,
        output ready
    );
endinterface

>>> sv/keplerian_to_equinoctial_top.sv
`timescale 1ns / 1ps
// Top level of the Keplerian to modified equinoctial element converter.
//
//  channel   dir  handshake     payload
//  item_in   in   valid/ready   semimajor_km, eccentricity, inclination, node, perigee, anomaly
//  item_out  out  valid/ready   semilatus_km, ecc_cos/sin, tilt_cos/sin, longitude_sum, saturated
//
// One item per cycle sustained while the output is not stalled; the depth is set by the
// CORDIC pipeline and the restoring divider.
// rst_n clears only the valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline and drops input ready.
module keplerian_to_equinoctial_top #(
    parameter int ANGLE_BITS    = k2e_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = k2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    k2e_in_if.sink      item_in,
    k2e_out_if.source   item_out
);

    localparam int A_W        = k2e_pkg::A_W;
    localparam int E_W        = k2e_pkg::E_W;
    localparam int ANG_W      = k2e_pkg::ANG_W;
    localparam int TRIG_W     = k2e_pkg::TRIG_W;
    localparam int NUM_W      = k2e_pkg::NUM_W;
    localparam int DEN_W      = k2e_pkg::DEN_W;
    localparam int QUO_W      = k2e_pkg::QUO_W;
    localparam int OUT_W      = k2e_pkg::OUT_W;
    localparam int PP_W       = k2e_pkg::PP_W;
    localparam int MAG_W      = k2e_pkg::MAG_W;
    localparam int EPROD_W    = k2e_pkg::EPROD_W;
    localparam int CORDIC_LAT = CORDIC_STAGES + 1;
    localparam int DIV_LAT    = QUO_W + 1;
    localparam int TAIL_DEPTH = DIV_LAT - 3;
    localparam int PIPE_DEPTH = CORDIC_LAT + DIV_LAT + 4;
    localparam int HEAD_W     = A_W + 1 + E_W + ANG_W;
    localparam int SIDE_W     = $bits(k2e_pkg::side_t);
    localparam logic [ANG_W-1:0] ANGLE_MASK =
        ~((ANG_W'(1) << (ANG_W - ANGLE_BITS)) - ANG_W'(1));
    localparam logic [63:0] ONE_Q56 = 64'd1 << 56;
    localparam logic [MAG_W-1:0] P_POS_MAX = MAG_W'((64'd1 << 47) - 64'd1);
    localparam logic [MAG_W-1:0] P_NEG_MAX = MAG_W'(64'd1 << 47);

    function automatic k2e_pkg::tilt_res_t tilt_final(
        input logic             den_zero,
        input logic             den_neg,
        input logic             n_zero,
        input logic             n_neg,
        input logic             ovf,
        input logic [QUO_W-1:0] q
    );
        k2e_pkg::tilt_res_t r;
        r.value = '0;
        r.sat   = 1'b0;
        if (den_zero)
        begin
            if (!n_zero)
            begin
                r.sat   = 1'b1;
                r.value = n_neg ? k2e_pkg::OUT_MIN : k2e_pkg::OUT_MAX;
            end
        end
        else if (ovf)
        begin
            r.sat   = 1'b1;
            r.value = (n_neg ^ den_neg) ? k2e_pkg::OUT_MIN : k2e_pkg::OUT_MAX;
        end
        else if (n_neg ^ den_neg)
        begin
            if (q > QUO_W'(33'h0_8000_0000))
            begin
                r.sat   = 1'b1;
                r.value = k2e_pkg::OUT_MIN;
            end
            else
            begin
                r.value = OUT_W'(-q);
            end
        end
        else if (q > QUO_W'(33'h0_7FFF_FFFF))
        begin
            r.sat   = 1'b1;
            r.value = k2e_pkg::OUT_MAX;
        end
        else
        begin
            r.value = OUT_W'(q);
        end
        return r;
    endfunction

    logic                  en;
    logic [PIPE_DEPTH-1:0] valid_reg;

    assign en            = !valid_reg[PIPE_DEPTH-1] || item_out.ready;
    assign item_in.ready = en;
    assign item_out.valid = valid_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], item_in.valid};
        end
    end

    // input capture
    logic [A_W-1:0]   raw_a;
    logic [A_W-1:0]   a_mag_next;
    logic [ANG_W-1:0] inc_m, node_m, per_m, anom_m;
    logic [A_W-1:0]   a_mag_reg;
    logic             a_neg_reg;
    logic [E_W-1:0]   e_reg;
    logic [ANG_W-1:0] ang_w_reg, node_reg, half_inc_reg, lsum_reg;

    always_comb
    begin
        raw_a      = item_in.semimajor_km;
        a_mag_next = raw_a[A_W-1] ? (~raw_a + A_W'(1)) : raw_a;
        inc_m      = item_in.inclination & ANGLE_MASK;
        node_m     = item_in.node_longitude & ANGLE_MASK;
        per_m      = item_in.perigee_argument & ANGLE_MASK;
        anom_m     = item_in.anomaly & ANGLE_MASK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg    <= a_mag_next;
            a_neg_reg    <= raw_a[A_W-1];
            e_reg        <= item_in.eccentricity;
            ang_w_reg    <= per_m + node_m;
            node_reg     <= node_m;
            half_inc_reg <= inc_m >> 1;
            lsum_reg     <= node_m + per_m + anom_m;
        end
    end

    // trigonometry
    logic signed [TRIG_W-1:0] cw_c, sw_c, co_c, so_c, ch_c, sh_c;

    k2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_w (
        .clk(clk), .en(en), .angle(ang_w_reg), .cos_val(cw_c), .sin_val(sw_c)
    );
    k2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_node (
        .clk(clk), .en(en), .angle(node_reg), .cos_val(co_c), .sin_val(so_c)
    );
    k2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_inc (
        .clk(clk), .en(en), .angle(half_inc_reg), .cos_val(ch_c), .sin_val(sh_c)
    );

    logic [HEAD_W-1:0] head_out;
    logic [A_W-1:0]    a_mag_h;
    logic              a_neg_h;
    logic [E_W-1:0]    e_h;
    logic [ANG_W-1:0]  lsum_h;

    k2e_delay #(.WIDTH(HEAD_W), .DEPTH(CORDIC_LAT)) u_head_delay (
        .clk(clk), .en(en),
        .data_in({a_mag_reg, a_neg_reg, e_reg, lsum_reg}),
        .data_out(head_out)
    );
    assign {a_mag_h, a_neg_h, e_h, lsum_h} = head_out;

    // stage B: trig values and e squared
    logic signed [TRIG_W-1:0] cw_b_reg, sw_b_reg, co_b_reg, so_b_reg, ch_b_reg, sh_b_reg;
    logic [E_W-1:0]   e_b_reg;
    logic [63:0]      e2_b_reg;
    logic [A_W-1:0]   a_mag_b_reg;
    logic             a_neg_b_reg;
    logic [ANG_W-1:0] lsum_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cw_b_reg    <= cw_c;
            sw_b_reg    <= sw_c;
            co_b_reg    <= co_c;
            so_b_reg    <= so_c;
            ch_b_reg    <= ch_c;
            sh_b_reg    <= sh_c;
            e_b_reg     <= e_h;
            e2_b_reg    <= 64'(e_h) * 64'(e_h);
            a_mag_b_reg <= a_mag_h;
            a_neg_b_reg <= a_neg_h;
            lsum_b_reg  <= lsum_h;
        end
    end

    // stage C: products
    logic signed [EPROD_W-1:0] ecc_prod_c_reg, ecc_prod_s_reg;
    logic signed [NUM_W-1:0]   num_h_reg, num_k_reg;
    logic signed [TRIG_W-1:0]  ch_c_reg;
    logic [63:0]               dmag_c_reg;
    logic                      dneg_c_reg;
    logic [A_W-1:0]            a_mag_c_reg;
    logic                      a_neg_c_reg;
    logic [ANG_W-1:0]          lsum_c_reg;
    logic signed [EPROD_W-1:0] e_ext;

    assign e_ext = EPROD_W'($signed({1'b0, e_b_reg}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ecc_prod_c_reg <= e_ext * EPROD_W'(cw_b_reg);
            ecc_prod_s_reg <= e_ext * EPROD_W'(sw_b_reg);
            num_h_reg      <= NUM_W'(sh_b_reg) * NUM_W'(co_b_reg);
            num_k_reg      <= NUM_W'(sh_b_reg) * NUM_W'(so_b_reg);
            ch_c_reg       <= ch_b_reg;
            dneg_c_reg     <= e2_b_reg > ONE_Q56;
            dmag_c_reg     <= (e2_b_reg > ONE_Q56) ? (e2_b_reg - ONE_Q56)
                                                   : (ONE_Q56 - e2_b_reg);
            a_mag_c_reg    <= a_mag_b_reg;
            a_neg_c_reg    <= a_neg_b_reg;
            lsum_c_reg     <= lsum_b_reg;
        end
    end

    // division of the tilt numerators
    logic [NUM_W-1:0]  num_h_mag, num_k_mag;
    logic [TRIG_W-1:0] ch_mag;
    logic [DEN_W-1:0]  den_mag;
    logic [QUO_W-1:0]  quo_h, quo_k;
    logic              ovf_h, ovf_k;

    always_comb
    begin
        num_h_mag = num_h_reg[NUM_W-1] ? NUM_W'(-num_h_reg) : NUM_W'(num_h_reg);
        num_k_mag = num_k_reg[NUM_W-1] ? NUM_W'(-num_k_reg) : NUM_W'(num_k_reg);
        ch_mag    = ch_c_reg[TRIG_W-1] ? TRIG_W'(-ch_c_reg) : TRIG_W'(ch_c_reg);
        den_mag   = DEN_W'(ch_mag) << 6;
    end

    k2e_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_h (
        .clk(clk), .en(en), .num_mag(num_h_mag), .den_mag(den_mag), .quo(quo_h), .ovf(ovf_h)
    );
    k2e_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_k (
        .clk(clk), .en(en), .num_mag(num_k_mag), .den_mag(den_mag), .quo(quo_k), .ovf(ovf_k)
    );

    // stage D: eccentricity terms, partial products of p
    logic signed [EPROD_W-1:0] ecc_rc, ecc_rs;
    logic signed [OUT_W-1:0]   ecc_c_next, ecc_s_next;
    logic                      ecc_sat_next;
    logic signed [OUT_W-1:0]   ecc_c_d_reg, ecc_s_d_reg;
    logic                      ecc_sat_d_reg;
    logic [PP_W-1:0]           pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic                      p_neg_d_reg;
    logic [ANG_W-1:0]          lsum_d_reg;
    k2e_pkg::tilt_flags_t      flags_d_reg;
    localparam logic signed [EPROD_W-1:0] RND   = EPROD_W'(1) <<< 29;
    localparam logic signed [EPROD_W-1:0] E_MAX = EPROD_W'(k2e_pkg::OUT_MAX);
    localparam logic signed [EPROD_W-1:0] E_MIN = EPROD_W'(k2e_pkg::OUT_MIN);

    always_comb
    begin
        ecc_rc       = (ecc_prod_c_reg + RND) >>> 30;
        ecc_rs       = (ecc_prod_s_reg + RND) >>> 30;
        ecc_sat_next = 1'b0;
        if (ecc_rc > E_MAX)
        begin
            ecc_c_next   = k2e_pkg::OUT_MAX;
            ecc_sat_next = 1'b1;
        end
        else if (ecc_rc < E_MIN)
        begin
            ecc_c_next   = k2e_pkg::OUT_MIN;
            ecc_sat_next = 1'b1;
        end
        else
        begin
            ecc_c_next = OUT_W'(ecc_rc);
        end
        if (ecc_rs > E_MAX)
        begin
            ecc_s_next   = k2e_pkg::OUT_MAX;
            ecc_sat_next = 1'b1;
        end
        else if (ecc_rs < E_MIN)
        begin
            ecc_s_next   = k2e_pkg::OUT_MIN;
            ecc_sat_next = 1'b1;
        end
        else
        begin
            ecc_s_next = OUT_W'(ecc_rs);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ecc_c_d_reg          <= ecc_c_next;
            ecc_s_d_reg          <= ecc_s_next;
            ecc_sat_d_reg        <= ecc_sat_next;
            pp00_reg             <= PP_W'(a_mag_c_reg[23:0]) * PP_W'(dmag_c_reg[31:0]);
            pp01_reg             <= PP_W'(a_mag_c_reg[23:0]) * PP_W'(dmag_c_reg[63:32]);
            pp10_reg             <= PP_W'(a_mag_c_reg[47:24]) * PP_W'(dmag_c_reg[31:0]);
            pp11_reg             <= PP_W'(a_mag_c_reg[47:24]) * PP_W'(dmag_c_reg[63:32]);
            p_neg_d_reg          <= a_neg_c_reg ^ dneg_c_reg;
            lsum_d_reg           <= lsum_c_reg;
            flags_d_reg.den_zero <= ch_c_reg == '0;
            flags_d_reg.den_neg  <= ch_c_reg[TRIG_W-1];
            flags_d_reg.h_zero   <= num_h_reg == '0;
            flags_d_reg.h_neg    <= num_h_reg[NUM_W-1];
            flags_d_reg.k_zero   <= num_k_reg == '0;
            flags_d_reg.k_neg    <= num_k_reg[NUM_W-1];
        end
    end

    // stage E: sum of partial products
    logic [111:0]            p_sum;
    logic [MAG_W-1:0]        mag_e_reg;
    logic                    p_neg_e_reg;
    logic signed [OUT_W-1:0] ecc_c_e_reg, ecc_s_e_reg;
    logic                    ecc_sat_e_reg;
    logic [ANG_W-1:0]        lsum_e_reg;
    k2e_pkg::tilt_flags_t    flags_e_reg;

    assign p_sum = 112'(pp00_reg) + (112'(pp01_reg) << 32) + (112'(pp10_reg) << 24)
                 + (112'(pp11_reg) << 56);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_e_reg     <= p_sum[111:56];
            p_neg_e_reg   <= p_neg_d_reg;
            ecc_c_e_reg   <= ecc_c_d_reg;
            ecc_s_e_reg   <= ecc_s_d_reg;
            ecc_sat_e_reg <= ecc_sat_d_reg;
            lsum_e_reg    <= lsum_d_reg;
            flags_e_reg   <= flags_d_reg;
        end
    end

    // stage F: clip p
    k2e_pkg::side_t side_next, side_f_reg, side_tail;
    logic [SIDE_W-1:0] side_tail_bits;

    always_comb
    begin
        side_next.p_sat = 1'b0;
        if (p_neg_e_reg)
        begin
            if (mag_e_reg > P_NEG_MAX)
            begin
                side_next.p_sat     = 1'b1;
                side_next.semilatus = A_W'(-P_NEG_MAX);
            end
            else
            begin
                side_next.semilatus = A_W'(-mag_e_reg);
            end
        end
        else if (mag_e_reg > P_POS_MAX)
        begin
            side_next.p_sat     = 1'b1;
            side_next.semilatus = A_W'(P_POS_MAX);
        end
        else
        begin
            side_next.semilatus = A_W'(mag_e_reg);
        end
        side_next.ecc_cos = ecc_c_e_reg;
        side_next.ecc_sin = ecc_s_e_reg;
        side_next.ecc_sat = ecc_sat_e_reg;
        side_next.lsum    = lsum_e_reg;
        side_next.flags   = flags_e_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_f_reg <= side_next;
        end
    end

    k2e_delay #(.WIDTH(SIDE_W), .DEPTH(TAIL_DEPTH)) u_tail_delay (
        .clk(clk), .en(en), .data_in(side_f_reg), .data_out(side_tail_bits)
    );
    assign side_tail = k2e_pkg::side_t'(side_tail_bits);

    // stage G: tilt terms and output register
    k2e_pkg::tilt_res_t tilt_h, tilt_k;
    logic signed [A_W-1:0]   semilatus_reg;
    logic signed [OUT_W-1:0] ecc_cos_reg, ecc_sin_reg, tilt_cos_reg, tilt_sin_reg;
    logic [ANG_W-1:0]        lsum_out_reg;
    logic                    sat_reg;

    always_comb
    begin
        tilt_h = tilt_final(side_tail.flags.den_zero, side_tail.flags.den_neg,
                            side_tail.flags.h_zero, side_tail.flags.h_neg, ovf_h, quo_h);
        tilt_k = tilt_final(side_tail.flags.den_zero, side_tail.flags.den_neg,
                            side_tail.flags.k_zero, side_tail.flags.k_neg, ovf_k, quo_k);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            semilatus_reg <= side_tail.semilatus;
            ecc_cos_reg   <= side_tail.ecc_cos;
            ecc_sin_reg   <= side_tail.ecc_sin;
            tilt_cos_reg  <= tilt_h.value;
            tilt_sin_reg  <= tilt_k.value;
            lsum_out_reg  <= side_tail.lsum;
            sat_reg       <= side_tail.p_sat | side_tail.ecc_sat | tilt_h.sat | tilt_k.sat;
        end
    end

    assign item_out.semilatus_km  = semilatus_reg;
    assign item_out.ecc_cos       = ecc_cos_reg;
    assign item_out.ecc_sin       = ecc_sin_reg;
    assign item_out.tilt_cos      = tilt_cos_reg;
    assign item_out.tilt_sin      = tilt_sin_reg;
    assign item_out.longitude_sum = lsum_out_reg;
    assign item_out.saturated     = sat_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item_out.valid && !item_out.ready) |-> !item_in.ready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready) |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_out.valid) |-> $past(valid_reg[PIPE_DEPTH-2]))
        else $error("output valid without an item behind it");

endmodule

>>> sv/k2e_delay.sv
`timescale 1ns / 1ps
// Enabled shift line that holds side data level with the deep units.
module k2e_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] data_in,
    output logic [WIDTH-1:0] data_out
);

    logic [WIDTH-1:0] stage_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= data_in;
            for (int i = 1; i < DEPTH; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign data_out = stage_reg[DEPTH-1];

endmodule

>>> sv/k2e_cordic.sv
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC giving cosine and sine of a binary angle.
module k2e_cordic #(
    parameter int STAGES = k2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [k2e_pkg::ANG_W-1:0]           angle,
    output logic signed [k2e_pkg::TRIG_W-1:0]   cos_val,
    output logic signed [k2e_pkg::TRIG_W-1:0]   sin_val
);

    localparam int XY_W = k2e_pkg::XY_W;
    localparam int Z_W  = k2e_pkg::Z_W;

    logic signed [XY_W-1:0] x_reg [STAGES+1];
    logic signed [XY_W-1:0] y_reg [STAGES+1];
    logic signed [Z_W-1:0]  z_reg [STAGES+1];
    logic                   flip_reg [STAGES+1];

    logic                          flip_next;
    logic [k2e_pkg::ANG_W-1:0]     fold;
    logic signed [Z_W-1:0]         z_next;

    always_comb
    begin
        flip_next = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
        fold      = flip_next ? (angle - 32'h8000_0000) : angle;
        z_next    = Z_W'($signed(fold));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= k2e_pkg::CORDIC_GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [Z_W-1:0] ARC = $signed(Z_W'(k2e_pkg::ARC_TABLE[i]));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][Z_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ARC;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ARC;
                end
            end
        end
    end

    assign cos_val = k2e_pkg::TRIG_W'(flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES]);
    assign sin_val = k2e_pkg::TRIG_W'(flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES]);

endmodule

>>> sv/k2e_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module k2e_divider #(
    parameter int NUM_W = k2e_pkg::NUM_W,
    parameter int DEN_W = k2e_pkg::DEN_W,
    parameter int QUO_W = k2e_pkg::QUO_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_mag,
    input  logic [DEN_W-1:0] den_mag,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);

    localparam int CMP_W = (DEN_W + QUO_W > NUM_W) ? DEN_W + QUO_W : NUM_W;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic             ovf_reg [QUO_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_mag;
            den_reg[0] <= den_mag;
            quo_reg[0] <= '0;
            ovf_reg[0] <= CMP_W'(num_mag) >= (CMP_W'(den_mag) << QUO_W);
        end
    end

    for (genvar s = 1; s <= QUO_W; s++)
    begin : g_step
        localparam int BIT = QUO_W - s;
        logic [CMP_W-1:0] trial;
        logic             take;

        assign trial = CMP_W'(den_reg[s-1]) << BIT;
        assign take  = CMP_W'(rem_reg[s-1]) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= quo_reg[s-1] | (QUO_W'(take) << BIT);
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end

        if (s < QUO_W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? NUM_W'(CMP_W'(rem_reg[s-1]) - trial)
                                       : rem_reg[s-1];
                    den_reg[s] <= den_reg[s-1];
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W];
    assign ovf = ovf_reg[QUO_W];

endmodule
